>>> sv/mcr_pkg.sv
// Shared constants and types for the midpoint circle rasterizer.
package mcr_pkg;

  // Fixed pixel coordinate width on the result side
  localparam int unsigned PIX_W = 13;
  // Packed result: {pixel_x, pixel_y, pixel_valid, last_pixel}
  localparam int unsigned RES_W = 2 * PIX_W + 2;
  // Depth of the command and result queues (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;

  // Command codes carried in the action field
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  // Square root unit sequencer
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_LOAD,
    SQ_ITER
  } sq_state_e;

  // Back-end sequencer
  typedef enum logic {
    ENG_READY,
    ENG_ROOT
  } eng_state_e;

endpackage

>>> sv/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer: command queue, engine, root unit, result queue.
//
// Usage: both channels behave as queues. Write a command with push while full is low;
// action 0 starts a circle from a center and a rim point, action 1 asks for the next
// pixel. Each command yields exactly one result, read while empty is low and taken
// with pop. A next command with no circle running returns an all-zero idle result.
// A next command passes from the command queue register through the engine's
// combinational step and pixel adder path into the result queue register, which
// drives the result ports. Once the engine takes a start command, the square root
// unit latches the offsets, squares and sums them, settles the COORD_BITS + 1 root
// bits and raises done; the engine then queues the first pixel. Throughput: one
// next command per cycle while the result queue has room, set by that path in the
// engine; start commands occupy the engine during the root search.
// Reset clears both queues and the circle state; no circle is active afterwards.
// When the receiver stalls, the result queue fills, the engine holds, the command
// queue fills and full rises; nothing is dropped.
module midpoint_circle_rasterizer #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command channel
  input  logic                               push,
  output logic                               full,
  input  logic                               action_i,
  input  logic [COORD_BITS-1:0]              center_x_i,
  input  logic [COORD_BITS-1:0]              center_y_i,
  input  logic [COORD_BITS-1:0]              rim_x_i,
  input  logic [COORD_BITS-1:0]              rim_y_i,
  // result channel
  output logic                               empty,
  input  logic                               pop,
  output logic signed [mcr_pkg::PIX_W-1:0]   pixel_x_o,
  output logic signed [mcr_pkg::PIX_W-1:0]   pixel_y_o,
  output logic                               pixel_valid_o,
  output logic                               last_pixel_o
);

  localparam int unsigned CMD_W = 4 * COORD_BITS + 1;
  localparam int unsigned PW    = mcr_pkg::PIX_W;

  logic [CMD_W-1:0]          cmd_wdata, cmd_rdata;
  logic                      cmd_empty, cmd_pop;
  logic [mcr_pkg::RES_W-1:0] res_wdata, res_rdata;
  logic                      res_full, res_push;
  logic                      root_start, root_done;
  logic [COORD_BITS-1:0]     root_dx, root_dy;
  logic [COORD_BITS:0]       root;

  // Pack the command transfer
  assign cmd_wdata = {action_i, center_x_i, center_y_i, rim_x_i, rim_y_i};

  mcr_fifo #(
    .W     (CMD_W),
    .DEPTH (mcr_pkg::QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_wdata),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  mcr_isqrt #(
    .COORD_BITS (COORD_BITS)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .dx_i    (root_dx),
    .dy_i    (root_dy),
    .done_o  (root_done),
    .root_o  (root)
  );

  mcr_engine #(
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_data_i   (cmd_rdata),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_data_o   (res_wdata),
    .root_start_o (root_start),
    .root_dx_o    (root_dx),
    .root_dy_o    (root_dy),
    .root_done_i  (root_done),
    .root_i       (root)
  );

  mcr_fifo #(
    .W     (mcr_pkg::RES_W),
    .DEPTH (mcr_pkg::QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  // Unpack the result transfer
  assign pixel_x_o     = res_rdata[2*PW+1:PW+2];
  assign pixel_y_o     = res_rdata[PW+1:2];
  assign pixel_valid_o = res_rdata[1];
  assign last_pixel_o  = res_rdata[0];

endmodule

>>> sv/mcr_fifo.sv
// Small register queue used between the front and back of the rasterizer.
module mcr_fifo #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = AW + 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push_ok;
  logic          pop_ok;

  // Qualify transfers against the fill level
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_ok ? rd_ptr_q + AW'(1) : rd_ptr_q;
    count_d  = count_q + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store incoming entries
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> sv/mcr_isqrt.sv
// Iterative integer square root of dx*dx + dy*dy, two radicand bits per cycle.
module mcr_isqrt #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] dx_i,
  input  logic [COORD_BITS-1:0] dy_i,
  output logic                  done_o,
  output logic [COORD_BITS:0]   root_o
);

  localparam int unsigned VW = 2 * COORD_BITS + 2;

  mcr_pkg::sq_state_e state_q, state_d;

  logic [COORD_BITS-1:0]   dx_q, dy_q;
  logic [2*COORD_BITS-1:0] sq_x, sq_y;
  logic [VW-1:0]           rem_q, res_q, bit_q;
  logic [VW-1:0]           trial;
  logic                    done_q;
  logic                    load_en;
  logic                    iter_en;
  logic                    last_iter;

  assign sq_x      = {{COORD_BITS{1'b0}}, dx_q} * {{COORD_BITS{1'b0}}, dx_q};
  assign sq_y      = {{COORD_BITS{1'b0}}, dy_q} * {{COORD_BITS{1'b0}}, dy_q};
  assign trial     = res_q + bit_q;
  assign last_iter = (bit_q == VW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mcr_pkg::SQ_IDLE: begin
        if (start_i) state_d = mcr_pkg::SQ_LOAD;
      end
      mcr_pkg::SQ_LOAD: begin
        state_d = mcr_pkg::SQ_ITER;
      end
      mcr_pkg::SQ_ITER: begin
        if (last_iter) state_d = mcr_pkg::SQ_IDLE;
      end
      default: begin
        state_d = mcr_pkg::SQ_IDLE;
      end
    endcase
  end

  // Datapath enables
  always_comb begin
    load_en = 1'b0;
    iter_en = 1'b0;
    case (state_q)
      mcr_pkg::SQ_LOAD: load_en = 1'b1;
      mcr_pkg::SQ_ITER: iter_en = 1'b1;
      default: begin
        load_en = 1'b0;
        iter_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcr_pkg::SQ_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_i) begin
        done_q <= 1'b0;
      end else if (iter_en && last_iter) begin
        done_q <= 1'b1;
      end
    end
  end

  // Capture operands, form the radicand, then settle one root bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dx_q <= dx_i;
      dy_q <= dy_i;
    end
    if (load_en) begin
      rem_q <= VW'(sq_x) + VW'(sq_y);
      res_q <= '0;
      bit_q <= VW'(1) << (VW - 2);
    end else if (iter_en) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[COORD_BITS:0];

endmodule

>>> sv/mcr_engine.sv
// Back end: holds the circle state, runs midpoint steps and forms pixels.
module mcr_engine #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command queue side
  input  logic [4*COORD_BITS:0]       cmd_data_i,
  input  logic                        cmd_empty_i,
  output logic                        cmd_pop_o,
  // result queue side
  input  logic                        res_full_i,
  output logic                        res_push_o,
  output logic [mcr_pkg::RES_W-1:0]   res_data_o,
  // square root unit
  output logic                        root_start_o,
  output logic [COORD_BITS-1:0]       root_dx_o,
  output logic [COORD_BITS-1:0]       root_dy_o,
  input  logic                        root_done_i,
  input  logic [COORD_BITS:0]         root_i
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned OW = C + 2;
  localparam int unsigned DW = C + 6;
  localparam int unsigned SW = (C + 3 > mcr_pkg::PIX_W) ? C + 3 : mcr_pkg::PIX_W;
  localparam int unsigned PW = mcr_pkg::PIX_W;

  mcr_pkg::eng_state_e state_q, state_d;

  logic [C-1:0]          center_x_q, center_y_q;
  logic signed [OW-1:0]  step_x_q, step_y_q;
  logic signed [DW-1:0]  decision_q;
  logic [2:0]            octant_q;
  logic                  active_q;

  logic                  cmd_action;
  logic [C-1:0]          cmd_cx, cmd_cy, cmd_rx, cmd_ry;
  logic                  take_cmd;
  logic                  take_start;
  logic                  take_next;
  logic                  root_finish;

  logic signed [DW-1:0]  xe, ye, dec_step;
  logic signed [OW-1:0]  cur_x, cur_y, off_x, off_y;
  logic [SW-1:0]         sum_x, sum_y;
  logic                  last_pix;
  logic [PW-1:0]         pix_x, pix_y;
  logic                  pix_valid;

  // Unpack the command
  assign cmd_action = cmd_data_i[4*C];
  assign cmd_cx     = cmd_data_i[4*C-1:3*C];
  assign cmd_cy     = cmd_data_i[3*C-1:2*C];
  assign cmd_rx     = cmd_data_i[2*C-1:C];
  assign cmd_ry     = cmd_data_i[C-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mcr_pkg::ENG_READY: begin
        if (!cmd_empty_i && !res_full_i && cmd_action == mcr_pkg::ACT_START) begin
          state_d = mcr_pkg::ENG_ROOT;
        end
      end
      mcr_pkg::ENG_ROOT: begin
        if (root_done_i && !res_full_i) state_d = mcr_pkg::ENG_READY;
      end
      default: begin
        state_d = mcr_pkg::ENG_READY;
      end
    endcase
  end

  // Handshake outputs
  always_comb begin
    take_cmd    = 1'b0;
    root_finish = 1'b0;
    case (state_q)
      mcr_pkg::ENG_READY: take_cmd = !cmd_empty_i && !res_full_i;
      mcr_pkg::ENG_ROOT:  root_finish = root_done_i && !res_full_i;
      default: begin
        take_cmd    = 1'b0;
        root_finish = 1'b0;
      end
    endcase
  end

  assign take_start   = take_cmd && (cmd_action == mcr_pkg::ACT_START);
  assign take_next    = take_cmd && (cmd_action == mcr_pkg::ACT_NEXT);
  assign cmd_pop_o    = take_cmd;
  assign res_push_o   = take_next || root_finish;
  assign root_start_o = take_start;
  assign root_dx_o    = (cmd_rx > cmd_cx) ? cmd_rx - cmd_cx : cmd_cx - cmd_rx;
  assign root_dy_o    = (cmd_ry > cmd_cy) ? cmd_ry - cmd_cy : cmd_cy - cmd_ry;

  // Midpoint step, applied on the first of each group of eight pixels
  assign xe = DW'(step_x_q);
  assign ye = DW'(step_y_q);
  always_comb begin
    if (decision_q < 0) begin
      dec_step = decision_q + xe + xe + DW'(3);
    end else begin
      dec_step = decision_q + xe + xe - ye - ye + DW'(5);
    end
    if (octant_q == 3'd0) begin
      cur_x = step_x_q + OW'(1);
      cur_y = (decision_q < 0) ? step_y_q : step_y_q - OW'(1);
    end else begin
      cur_x = step_x_q;
      cur_y = step_y_q;
    end
  end

  // Pick the symmetric offset for this pixel
  always_comb begin
    last_pix = 1'b0;
    case (octant_q)
      3'd0: begin off_x = cur_x;  off_y = cur_y;  end
      3'd1: begin off_x = cur_x;  off_y = -cur_y; end
      3'd2: begin off_x = -cur_x; off_y = cur_y;  end
      3'd3: begin off_x = -cur_x; off_y = -cur_y; end
      3'd4: begin off_x = cur_y;  off_y = cur_x;  end
      3'd5: begin off_x = cur_y;  off_y = -cur_x; end
      3'd6: begin off_x = -cur_y; off_y = cur_x;  end
      default: begin
        off_x    = -cur_y;
        off_y    = -cur_x;
        last_pix = (cur_x > cur_y);
      end
    endcase
  end

  // Form the result: start pixel, stepped pixel or idle
  always_comb begin
    if (root_finish) begin
      sum_x     = SW'(center_x_q);
      sum_y     = SW'(center_y_q) + SW'(root_i);
      pix_valid = 1'b1;
    end else begin
      sum_x     = SW'(center_x_q) + SW'(off_x);
      sum_y     = SW'(center_y_q) + SW'(off_y);
      pix_valid = active_q;
    end
    pix_x = pix_valid ? sum_x[PW-1:0] : '0;
    pix_y = pix_valid ? sum_y[PW-1:0] : '0;
  end

  assign res_data_o = {pix_x, pix_y, pix_valid, pix_valid && !root_finish && last_pix};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mcr_pkg::ENG_READY;
      center_x_q <= '0;
      center_y_q <= '0;
      step_x_q   <= '0;
      step_y_q   <= '0;
      decision_q <= '0;
      octant_q   <= '0;
      active_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take_start) begin
        // latch the new center and drop any circle in flight
        center_x_q <= cmd_cx;
        center_y_q <= cmd_cy;
        active_q   <= 1'b0;
      end else if (root_finish) begin
        step_x_q   <= '0;
        step_y_q   <= OW'(root_i);
        decision_q <= DW'(1) - DW'(root_i);
        octant_q   <= '0;
        active_q   <= 1'b1;
      end else if (take_next && active_q) begin
        if (octant_q == 3'd0) begin
          step_x_q   <= cur_x;
          step_y_q   <= cur_y;
          decision_q <= dec_step;
        end
        octant_q <= octant_q + 3'd1;
        if (octant_q == 3'd7 && last_pix) begin
          active_q <= 1'b0;
        end
      end
    end
  end

endmodule

>>> tb/midpoint_circle_rasterizer_tb.sv
// Self-checking testbench for the midpoint circle rasterizer with a predicting scoreboard.
module midpoint_circle_rasterizer_tb;

  localparam int COORD_BITS = 10;
  localparam int NUM_ITEMS  = 1300;
  localparam int CYCLE_CAP  = 400000;
  // Root search plus queue stages, with margin
  localparam int SETTLE_CYCLES = COORD_BITS + 12;

  typedef logic [COORD_BITS-1:0]     coord_t;
  typedef logic [mcr_pkg::PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t x;
    pix_t y;
    logic valid;
    logic last;
  } pixel_t;

  // Predicts the pixel stream and checks each result against the oldest prediction
  class circle_scoreboard;
    pixel_t     pending_pixels[$];
    int         org_x, org_y;
    int         walk_x, walk_y, err_term;
    int         octant;
    bit         running;
    int         errors, circles, circles_done, pixels_seen, idles_seen;

    function new();
      org_x = 0; org_y = 0; walk_x = 0; walk_y = 0; err_term = 0;
      octant = 0; running = 0;
      errors = 0; circles = 0; circles_done = 0; pixels_seen = 0; idles_seen = 0;
    endfunction

    function automatic int unsigned root_floor(int unsigned v);
      int unsigned r, t;
      r = 0;
      for (int b = 11; b >= 0; b--) begin
        t = r | (32'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function automatic pixel_t place(int ox, int oy, logic last);
      pixel_t p;
      p.x = pix_t'(org_x + ox);
      p.y = pix_t'(org_y + oy);
      p.valid = 1'b1;
      p.last = last;
      return p;
    endfunction

    // Advance the circle state for one accepted command and queue its pixel
    function void note_command(logic act, coord_t cx, coord_t cy, coord_t rx, coord_t ry);
      int dx, dy, r;
      logic last;
      pixel_t p;
      last = 1'b0;
      if (act == mcr_pkg::ACT_START) begin
        dx = (rx > cx) ? int'(rx) - int'(cx) : int'(cx) - int'(rx);
        dy = (ry > cy) ? int'(ry) - int'(cy) : int'(cy) - int'(ry);
        r = int'(root_floor(dx * dx + dy * dy));
        org_x = cx; org_y = cy;
        walk_x = 0; walk_y = r; err_term = 1 - r;
        octant = 0; running = 1; circles++;
        pending_pixels.push_back(place(0, r, 1'b0));
        return;
      end
      if (!running) begin
        pending_pixels.push_back('0);
        return;
      end
      // One midpoint step at the start of each group of eight
      if (octant == 0) begin
        walk_x++;
        if (err_term < 0) err_term += 2 * walk_x + 1;
        else begin
          walk_y--;
          err_term += 2 * walk_x - 2 * walk_y + 1;
        end
      end
      case (octant)
        0: p = place(walk_x, walk_y, 1'b0);
        1: p = place(walk_x, -walk_y, 1'b0);
        2: p = place(-walk_x, walk_y, 1'b0);
        3: p = place(-walk_x, -walk_y, 1'b0);
        4: p = place(walk_y, walk_x, 1'b0);
        5: p = place(walk_y, -walk_x, 1'b0);
        6: p = place(-walk_y, walk_x, 1'b0);
        default: begin
          last = (walk_x > walk_y);
          p = place(-walk_y, -walk_x, last);
        end
      endcase
      pending_pixels.push_back(p);
      if (octant == 7) begin
        octant = 0;
        if (last) begin
          running = 0;
          circles_done++;
        end
      end else begin
        octant++;
      end
    endfunction

    // Compare one transferred result with the oldest prediction
    function void check_pixel(pix_t px, pix_t py, logic valid, logic last);
      pixel_t e;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: x=%0d y=%0d valid=%0b last=%0b",
               $signed(px), $signed(py), valid, last);
        errors++;
        return;
      end
      e = pending_pixels.pop_front();
      if (e.valid) pixels_seen++;
      else idles_seen++;
      if (px !== e.x) begin
        $error("pixel_x: expected %0d, got %0d", $signed(e.x), $signed(px));
        errors++;
      end
      if (py !== e.y) begin
        $error("pixel_y: expected %0d, got %0d", $signed(e.y), $signed(py));
        errors++;
      end
      if (valid !== e.valid) begin
        $error("pixel_valid: expected %0b, got %0b", e.valid, valid);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_pixel: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   push = 1'b0;
  logic   pop = 1'b0;
  logic   action_i = mcr_pkg::ACT_NEXT;
  coord_t center_x_i = '0;
  coord_t center_y_i = '0;
  coord_t rim_x_i = '0;
  coord_t rim_y_i = '0;
  logic   full, empty, pixel_valid_o, last_pixel_o;
  logic signed [mcr_pkg::PIX_W-1:0] pixel_x_o, pixel_y_o;

  circle_scoreboard sb = new();
  int sent_count = 0;
  int burst_left = 0;
  int pop_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  midpoint_circle_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
    .clk_i, .rst_ni,
    .push, .full, .action_i, .center_x_i, .center_y_i, .rim_x_i, .rim_y_i,
    .empty, .pop, .pixel_x_o, .pixel_y_o, .pixel_valid_o, .last_pixel_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_CAP) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // Receiver: switch between free flow, random pop and occasional long stalls
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      pop_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(3, 20);
          pop <= 1'b1;
        end
      endcase
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_pixel(pixel_x_o, pixel_y_o, pixel_valid_o, last_pixel_o);
  end

  // Drive one command and hold it until the transfer; bursts with random gaps
  task automatic send_item(logic act, coord_t cx, coord_t cy, coord_t rx, coord_t ry);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(150, 300)
                                               : $urandom_range(1, 30);
    end
    push <= 1'b1;
    action_i <= act;
    center_x_i <= cx;
    center_y_i <= cy;
    rim_x_i <= rx;
    rim_y_i <= ry;
    do @(posedge clk_i); while (full);
    sb.note_command(act, cx, cy, rx, ry);
    sent_count++;
    burst_left--;
  endtask

  task automatic request_pixel();
    send_item(mcr_pkg::ACT_NEXT, coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom));
  endtask

  // Hold off the sender until every predicted result has been transferred
  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Start a circle near a random center and walk it, sometimes cutting it short
  task automatic random_circle();
    int span, cut, steps;
    coord_t cx, cy;
    span = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, 30);
    cx = coord_t'($urandom);
    cy = coord_t'($urandom);
    send_item(mcr_pkg::ACT_START, cx, cy,
              coord_t'(int'(cx) + $urandom_range(0, 2 * span) - span),
              coord_t'(int'(cy) + $urandom_range(0, 2 * span) - span));
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 30) : 32'h7fffffff;
    steps = 0;
    while (sb.running && steps < cut && sent_count < NUM_ITEMS) begin
      request_pixel();
      steps++;
    end
    // Ask past the end of the circle now and then
    if (!sb.running && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 2)) request_pixel();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Next with no circle running gives an idle result
    request_pixel();
    // Zero radius: one step, eight pixels, last on the eighth
    send_item(mcr_pkg::ACT_START, '0, '0, '0, '0);
    repeat (8) request_pixel();
    request_pixel();
    // Largest radius from the low corner: offsets wrap below zero
    send_item(mcr_pkg::ACT_START, '0, '0, '1, '1);
    repeat (8) request_pixel();
    // Restart while a circle is active, from the high corner
    send_item(mcr_pkg::ACT_START, '1, '1, '0, '0);
    repeat (3) request_pixel();
    send_item(mcr_pkg::ACT_START, coord_t'(512), coord_t'(512), coord_t'(515),
              coord_t'(512));
    drain();

    // Random part: mostly well-formed circles, some noise commands
    while (sent_count < NUM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom));
      end else begin
        random_circle();
        if ($urandom_range(0, 7) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("summary: %0d commands, %0d circles started, %0d run to their last pixel",
             sent_count, sb.circles, sb.circles_done);
    $display("summary: %0d pixels and %0d idle results checked",
             sb.pixels_seen, sb.idles_seen);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
